// ----- hdl/bsr_pkg.sv -----
// ============================================================================
// bsr_pkg
// Shared types and constants for the BMP byte stream to RGBA converter.
// ============================================================================
`timescale 1ns / 1ps

package bsr_pkg;

  // Output coordinate width
  localparam int COORD_W = 12;

  // Parse phases
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // Result status codes
  localparam logic [1:0] ST_PIXEL     = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd2;

  // Header byte positions
  localparam logic [31:0] POS_MAGIC_LO  = 32'd0;
  localparam logic [31:0] POS_MAGIC_HI  = 32'd1;
  localparam logic [31:0] POS_OFS_FIRST = 32'd10;
  localparam logic [31:0] POS_OFS_LAST  = 32'd13;
  localparam logic [31:0] POS_WID_FIRST = 32'd18;
  localparam logic [31:0] POS_WID_LAST  = 32'd21;
  localparam logic [31:0] POS_HGT_FIRST = 32'd22;
  localparam logic [31:0] POS_HGT_LAST  = 32'd25;
  localparam logic [31:0] POS_BPP_LO    = 32'd28;
  localparam logic [31:0] POS_BPP_HI    = 32'd29;

  // Magic, depth and alpha constants
  localparam logic [7:0]  MAGIC_B      = 8'h42;
  localparam logic [7:0]  MAGIC_M      = 8'h4D;
  localparam logic [15:0] BPP_32       = 16'd32;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [31:0]        pixel_rgba;
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
    logic               last_pixel;
    logic [1:0]         status;
  } out_item_t;

endpackage

// ----- hdl/bsr_parse.sv -----
// ============================================================================
// bsr_parse
// Header parser and pixel assembler: one byte per step, at most one result.
// ============================================================================
`timescale 1ns / 1ps

module bsr_parse #(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  bsr_pkg::in_item_t   item,
  input  logic                flip_rows,
  output logic                res_valid,
  output bsr_pkg::out_item_t  res
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int EXT_W = (DIM_W > bsr_pkg::COORD_W) ? DIM_W : bsr_pkg::COORD_W;
  localparam logic [31:0] MAX_DIM_W32 = 32'(MAX_DIM);

  // State registers
  bsr_pkg::phase_t   phase_r, phase_nxt;
  logic [31:0]       pos_r, pos_nxt;
  logic [31:0]       offset_r, offset_nxt;
  logic [31:0]       width_r, width_nxt;
  logic [31:0]       height_r, height_nxt;
  logic              four_r, four_nxt;
  logic [23:0]       pbytes_r, pbytes_nxt;
  logic [1:0]        bip_r, bip_nxt;
  logic [1:0]        pad_r, pad_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;

  // State as seen by this byte (file_start clears first)
  bsr_pkg::phase_t   cur_phase;
  logic [31:0]       cur_pos, cur_offset, cur_width, cur_height;
  logic              cur_four;
  logic [23:0]       cur_pbytes;
  logic [1:0]        cur_bip, cur_pad;
  logic [DIM_W-1:0]  cur_col, cur_row;

  // Decode
  logic [7:0]        b;
  logic [1:0]        lane;
  logic [31:0]       lane_word;
  logic [31:0]       full_h;
  logic              bad_magic, bad_size;
  logic              skip_done, pix_active, pad_active, pix_more, pix_emit;
  logic [31:0]       pix_full;
  logic [DIM_W-1:0]  width_d, height_d;
  logic              col_wrap, pix_last;
  logic [DIM_W-1:0]  row_sel;
  logic [EXT_W-1:0]  row_ext, col_ext;

  // Cleared view and shared decode
  always_comb begin
    b          = item.data_byte;
    cur_phase  = item.file_start ? bsr_pkg::PH_HEADER : phase_r;
    cur_pos    = item.file_start ? 32'd0 : pos_r;
    cur_offset = item.file_start ? 32'd0 : offset_r;
    cur_width  = item.file_start ? 32'd0 : width_r;
    cur_height = item.file_start ? 32'd0 : height_r;
    cur_four   = item.file_start ? 1'b0 : four_r;
    cur_pbytes = item.file_start ? 24'd0 : pbytes_r;
    cur_bip    = item.file_start ? 2'd0 : bip_r;
    cur_pad    = item.file_start ? 2'd0 : pad_r;
    cur_col    = item.file_start ? '0 : col_r;
    cur_row    = item.file_start ? '0 : row_r;

    // Little-endian fields all start at a position whose low bits are 2
    lane      = cur_pos[1:0] - 2'd2;
    lane_word = {24'd0, b} << {lane, 3'b000};
    full_h    = cur_height | lane_word;

    bad_magic = (cur_phase == bsr_pkg::PH_HEADER) && (cur_pos == bsr_pkg::POS_MAGIC_HI) &&
                !((cur_pbytes == {16'd0, bsr_pkg::MAGIC_B}) && (b == bsr_pkg::MAGIC_M));
    bad_size  = (cur_phase == bsr_pkg::PH_HEADER) && (cur_pos == bsr_pkg::POS_HGT_LAST) &&
                ((cur_width == 32'd0) || (cur_width > MAX_DIM_W32) ||
                 (full_h == 32'd0) || (full_h > MAX_DIM_W32));

    // Pixel assembly
    skip_done  = (cur_pos >= cur_offset);
    pix_active = (cur_phase == bsr_pkg::PH_PIXELS) ||
                 ((cur_phase == bsr_pkg::PH_SKIP) && skip_done);
    pad_active = (cur_pad != 2'd0);
    pix_full   = {8'd0, cur_pbytes} | ({24'd0, b} << {cur_bip, 3'b000});
    pix_more   = cur_four ? (cur_bip != 2'd3) : (cur_bip != 2'd2);
    pix_emit   = pix_active && !pad_active && !pix_more;

    width_d  = cur_width[DIM_W-1:0];
    height_d = cur_height[DIM_W-1:0];
    col_wrap = (cur_col == width_d - DIM_W'(1));
    pix_last = col_wrap && (cur_row == height_d - DIM_W'(1));

    row_sel = flip_rows ? (height_d - DIM_W'(1) - cur_row) : cur_row;
    row_ext = EXT_W'(row_sel);
    col_ext = EXT_W'(cur_col);
  end

  // Next phase
  always_comb begin
    unique case (cur_phase)
      bsr_pkg::PH_HEADER: begin
        if (bad_magic || bad_size) phase_nxt = bsr_pkg::PH_ERROR;
        else if (cur_pos == bsr_pkg::POS_BPP_HI) phase_nxt = bsr_pkg::PH_SKIP;
        else phase_nxt = bsr_pkg::PH_HEADER;
      end
      bsr_pkg::PH_SKIP: begin
        if (!skip_done) phase_nxt = bsr_pkg::PH_SKIP;
        else if (pix_emit && pix_last) phase_nxt = bsr_pkg::PH_DONE;
        else phase_nxt = bsr_pkg::PH_PIXELS;
      end
      bsr_pkg::PH_PIXELS: begin
        phase_nxt = (pix_emit && pix_last) ? bsr_pkg::PH_DONE : bsr_pkg::PH_PIXELS;
      end
      bsr_pkg::PH_DONE:  phase_nxt = bsr_pkg::PH_DONE;
      bsr_pkg::PH_ERROR: phase_nxt = bsr_pkg::PH_ERROR;
      default:           phase_nxt = bsr_pkg::PH_HEADER;
    endcase
  end

  // Result item
  always_comb begin
    res       = '0;
    res_valid = step && (bad_magic || bad_size || pix_emit);
    priority if (bad_magic) begin
      res.status = bsr_pkg::ST_BAD_MAGIC;
    end else if (bad_size) begin
      res.status = bsr_pkg::ST_BAD_SIZE;
    end else begin
      // Stored order is B,G,R(,A); swap red and blue
      res.pixel_rgba   = {cur_four ? pix_full[31:24] : bsr_pkg::ALPHA_OPAQUE,
                          pix_full[7:0], pix_full[15:8], pix_full[23:16]};
      res.pixel_column = col_ext[bsr_pkg::COORD_W-1:0];
      res.pixel_row    = row_ext[bsr_pkg::COORD_W-1:0];
      res.last_pixel   = pix_last;
      res.status       = bsr_pkg::ST_PIXEL;
    end
  end

  // Next parse state
  always_comb begin
    pos_nxt    = cur_pos;
    offset_nxt = cur_offset;
    width_nxt  = cur_width;
    height_nxt = cur_height;
    four_nxt   = cur_four;
    pbytes_nxt = cur_pbytes;
    bip_nxt    = cur_bip;
    pad_nxt    = cur_pad;
    col_nxt    = cur_col;
    row_nxt    = cur_row;

    // Header fields
    if ((cur_phase == bsr_pkg::PH_HEADER) && !bad_magic && !bad_size) begin
      pos_nxt = cur_pos + 32'd1;
      if (cur_pos == bsr_pkg::POS_MAGIC_LO) pbytes_nxt = {16'd0, b};
      if ((cur_pos >= bsr_pkg::POS_OFS_FIRST) && (cur_pos <= bsr_pkg::POS_OFS_LAST))
        offset_nxt = cur_offset | lane_word;
      if ((cur_pos >= bsr_pkg::POS_WID_FIRST) && (cur_pos <= bsr_pkg::POS_WID_LAST))
        width_nxt = cur_width | lane_word;
      if ((cur_pos >= bsr_pkg::POS_HGT_FIRST) && (cur_pos <= bsr_pkg::POS_HGT_LAST))
        height_nxt = full_h;
      if (cur_pos == bsr_pkg::POS_BPP_LO) pbytes_nxt = {16'd0, b};
      if (cur_pos == bsr_pkg::POS_BPP_HI) begin
        four_nxt   = ({b, cur_pbytes[7:0]} == bsr_pkg::BPP_32);
        pbytes_nxt = 24'd0;
      end
    end

    // Skip up to the data offset, saturating
    if ((cur_phase == bsr_pkg::PH_SKIP) && !skip_done && (cur_pos != 32'hFFFF_FFFF))
      pos_nxt = cur_pos + 32'd1;

    // Pixel bytes, row padding, raster counters
    if (pix_active) begin
      if (pad_active) begin
        pad_nxt = cur_pad - 2'd1;
      end else if (pix_more) begin
        pbytes_nxt = pix_full[23:0];
        bip_nxt    = cur_bip + 2'd1;
      end else begin
        pbytes_nxt = 24'd0;
        bip_nxt    = 2'd0;
        if (col_wrap) begin
          col_nxt = '0;
          row_nxt = cur_row + DIM_W'(1);
          if (!cur_four) pad_nxt = cur_width[1:0];
        end else begin
          col_nxt = cur_col + DIM_W'(1);
        end
      end
    end
  end

  // State update on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bsr_pkg::PH_HEADER;
      pos_r    <= '0;
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      four_r   <= 1'b0;
      pbytes_r <= '0;
      bip_r    <= '0;
      pad_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      four_r   <= four_nxt;
      pbytes_r <= pbytes_nxt;
      bip_r    <= bip_nxt;
      pad_r    <= pad_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

// ----- hdl/bsr_outbuf.sv -----
// ============================================================================
// bsr_outbuf
// Output register with a one-item skid stage behind it.
// ============================================================================
`timescale 1ns / 1ps

module bsr_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bsr_pkg::out_item_t push_item,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bsr_pkg::out_item_t out_data
);

  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  bsr_pkg::out_item_t out_r, out_nxt;
  bsr_pkg::out_item_t skid_r, skid_nxt;
  logic               drain;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Output slot frees when empty or taken; skid item goes first
  always_comb begin
    drain          = !out_valid_r || out_ready;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (drain) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = push;
        skid_nxt       = push_item;
      end else begin
        out_valid_nxt  = push;
        out_nxt        = push_item;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_item;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- hdl/bmp_stream_to_rgba.sv -----
// ============================================================================
// bmp_stream_to_rgba
// BMP byte stream to RGBA pixel converter (24/32-bit, optional row flip).
// ============================================================================
//
//  channel | signals                          | item
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data      | one file byte + start flag
//  out     | out_valid, out_ready, out_data   | pixel or error status
//  cfg     | cfg_valid, cfg_ready, cfg_flip_rows | flip_rows register write
//
//  One byte per cycle while in_ready is high; each result is registered.
//  All per-byte work is the parser's single stage into the output register.
//  Reset (rst_n low, synchronous) clears parse state and flip_rows.
//  A one-item skid stage keeps in_ready high while one result waits; in_ready
//  drops only when both output register and skid stage hold items.
//
`timescale 1ns / 1ps

module bmp_stream_to_rgba #(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bsr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_flip_rows
);

  logic               flip_rows_r;
  logic               step;
  logic               res_valid;
  bsr_pkg::out_item_t res;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && in_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_rows_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      flip_rows_r <= cfg_flip_rows;
    end
  end

  bsr_parse #(
    .MAX_DIM (MAX_DIM)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (in_data),
    .flip_rows (flip_rows_r),
    .res_valid (res_valid),
    .res       (res)
  );

  bsr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_item (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/bsr_checker.sv -----
// ============================================================================
// bsr_checker
// Port-level checks for the BMP to RGBA converter, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps

module bsr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input bsr_pkg::out_item_t out_data,
  input logic               out_valid,
  input logic               out_ready
);

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result item keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // Error results carry an all-zero pixel payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != bsr_pkg::ST_PIXEL) |->
      (out_data.pixel_rgba == 32'd0) && (out_data.pixel_column == '0) &&
      (out_data.pixel_row == '0) && !out_data.last_pixel)
    else $error("error result with nonzero payload");

  // Input backpressure only when a result is already waiting
  a_ready_skid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output");

  // A result item only shows up after an input item was taken
  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result item without an accepted input item");

endmodule

bind bmp_stream_to_rgba bsr_checker u_bsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking bench for the BMP byte stream to RGBA converter.
// Feeds whole BMP files, both well-formed and broken, one byte per item.
// A scoreboard predicts each pixel or error status from the accepted
// bytes and checks the output items in order. Random stalls are applied
// on both channels, and the row flip register is written between files.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

  localparam int          DIM_LIMIT   = 4096;   // matches the default MAX_DIM
  localparam int          STALL_LIMIT = 2000;   // cycles without any handshake
  localparam int          DRAIN_GAP   = 4;      // settle cycles after last pixel
  localparam int          EDGE_PIXELS = 8;      // pixels sent of the largest images
  localparam logic [15:0] BPP_24      = 16'd24;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  bsr_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  bsr_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_flip_rows;

  bmp_stream_to_rgba i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_flip_rows (cfg_flip_rows)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Converter model state
  // --------------------------------------------------------------------------
  bsr_pkg::phase_t parse_ph;
  logic [31:0]     byte_pos;
  logic [31:0]     data_ofs;
  logic [31:0]     img_w;
  logic [31:0]     img_h;
  bit              quad_px;
  logic [23:0]     px_acc;
  int unsigned     px_byte_idx;
  int unsigned     pad_left;
  logic [31:0]     cur_col;
  logic [31:0]     cur_row;
  bit              flip_model;

  bsr_pkg::out_item_t pixels_due[$];

  // Run bookkeeping
  int  mismatches;
  int  stall_cycles;
  int  bytes_offered;
  int  files_sent;
  int  pixels_checked;
  int  errors_checked;
  int  flip_writes;
  int  long_hold_cycles;
  bit  src_idle_en;
  bit  sink_idle_en;

  logic [7:0] file_bytes[$];

  function automatic void clear_parser();
    parse_ph    = bsr_pkg::PH_HEADER;
    byte_pos    = '0;
    data_ofs    = '0;
    img_w       = '0;
    img_h       = '0;
    quad_px     = 1'b0;
    px_acc      = '0;
    px_byte_idx = 0;
    pad_left    = 0;
    cur_col     = '0;
    cur_row     = '0;
  endfunction

  // One pixel-data byte: skip row padding, gather BGR(A), emit RGBA
  function automatic bit take_pixel_byte(input logic [7:0] b,
                                         output bsr_pkg::out_item_t px);
    int unsigned need;
    logic [31:0] word;
    logic [31:0] out_row;
    bit          is_last;
    px   = '0;
    need = quad_px ? 4 : 3;
    if (pad_left != 0) begin
      pad_left--;
      return 1'b0;
    end
    word = {8'd0, px_acc} | ({24'd0, b} << (8 * px_byte_idx));
    if (px_byte_idx + 1 < need) begin
      px_acc = word[23:0];
      px_byte_idx++;
      return 1'b0;
    end
    if (!quad_px) word[31:24] = bsr_pkg::ALPHA_OPAQUE;
    out_row = flip_model ? (img_h - 1 - cur_row) : cur_row;
    is_last = (cur_col == img_w - 1) && (cur_row == img_h - 1);
    // stored order is B,G,R(,A); swap red and blue
    px.pixel_rgba   = {word[31:24], word[7:0], word[15:8], word[23:16]};
    px.pixel_column = cur_col[bsr_pkg::COORD_W-1:0];
    px.pixel_row    = out_row[bsr_pkg::COORD_W-1:0];
    px.last_pixel   = is_last;
    px.status       = bsr_pkg::ST_PIXEL;
    px_acc      = '0;
    px_byte_idx = 0;
    cur_col++;
    if (cur_col >= img_w) begin
      cur_col = '0;
      cur_row++;
      if (!quad_px) pad_left = img_w & 3;
    end
    if (is_last) parse_ph = bsr_pkg::PH_DONE;
    return 1'b1;
  endfunction

  // Advance the model by one accepted byte; returns 1 when a result is due
  function automatic bit convert_byte(input bsr_pkg::in_item_t item,
                                      output bsr_pkg::out_item_t res);
    logic [7:0]  b;
    logic [31:0] pos;
    b   = item.data_byte;
    res = '0;
    if (item.file_start) clear_parser();
    case (parse_ph)
      bsr_pkg::PH_HEADER: begin
        pos = byte_pos;
        if (pos == bsr_pkg::POS_MAGIC_LO) begin
          px_acc = {16'd0, b};
        end else if (pos == bsr_pkg::POS_MAGIC_HI) begin
          if (!(px_acc == bsr_pkg::MAGIC_B && b == bsr_pkg::MAGIC_M)) begin
            parse_ph   = bsr_pkg::PH_ERROR;
            res.status = bsr_pkg::ST_BAD_MAGIC;
            return 1'b1;
          end
        end else if (pos >= bsr_pkg::POS_OFS_FIRST && pos <= bsr_pkg::POS_OFS_LAST) begin
          data_ofs |= {24'd0, b} << (8 * (pos - bsr_pkg::POS_OFS_FIRST));
        end else if (pos >= bsr_pkg::POS_WID_FIRST && pos <= bsr_pkg::POS_WID_LAST) begin
          img_w |= {24'd0, b} << (8 * (pos - bsr_pkg::POS_WID_FIRST));
        end else if (pos >= bsr_pkg::POS_HGT_FIRST && pos <= bsr_pkg::POS_HGT_LAST) begin
          img_h |= {24'd0, b} << (8 * (pos - bsr_pkg::POS_HGT_FIRST));
          if (pos == bsr_pkg::POS_HGT_LAST && (img_w == 0 || img_w > DIM_LIMIT ||
                                               img_h == 0 || img_h > DIM_LIMIT)) begin
            parse_ph   = bsr_pkg::PH_ERROR;
            res.status = bsr_pkg::ST_BAD_SIZE;
            return 1'b1;
          end
        end else if (pos == bsr_pkg::POS_BPP_LO) begin
          px_acc = {16'd0, b};
        end else if (pos == bsr_pkg::POS_BPP_HI) begin
          quad_px  = ({b, px_acc[7:0]} == bsr_pkg::BPP_32);
          px_acc   = '0;
          parse_ph = bsr_pkg::PH_SKIP;
        end
        byte_pos++;
        return 1'b0;
      end
      bsr_pkg::PH_SKIP: begin
        if (byte_pos < data_ofs) begin
          if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
          return 1'b0;
        end
        parse_ph = bsr_pkg::PH_PIXELS;
        return take_pixel_byte(b, res);
      end
      bsr_pkg::PH_PIXELS: begin
        return take_pixel_byte(b, res);
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on input accept, compare on output accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bsr_pkg::out_item_t predicted;
    bsr_pkg::out_item_t want;
    bit                 activity;
    if (rst_n) begin
      activity = 1'b0;
      if (in_valid && in_ready) begin
        activity = 1'b1;
        if (convert_byte(in_data, predicted)) pixels_due.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        activity = 1'b1;
        if (pixels_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected item: rgba=%h col=%0d row=%0d last=%0b st=%0d",
                     $time, out_data.pixel_rgba, out_data.pixel_column,
                     out_data.pixel_row, out_data.last_pixel, out_data.status);
        end else begin
          want = pixels_due.pop_front();
          if (want.status == bsr_pkg::ST_PIXEL) pixels_checked++;
          else errors_checked++;
          if (out_data.pixel_rgba !== want.pixel_rgba ||
              out_data.pixel_column !== want.pixel_column ||
              out_data.pixel_row !== want.pixel_row ||
              out_data.last_pixel !== want.last_pixel ||
              out_data.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch exp: rgba=%h col=%0d row=%0d last=%0b st=%0d",
                       $time, want.pixel_rgba, want.pixel_column, want.pixel_row,
                       want.last_pixel, want.status);
              $display("[%0t]          got: rgba=%h col=%0d row=%0d last=%0b st=%0d",
                       $time, out_data.pixel_rgba, out_data.pixel_column,
                       out_data.pixel_row, out_data.last_pixel, out_data.status);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) activity = 1'b1;
      stall_cycles = activity ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog on handshake activity
  initial begin
    stall_cycles = 0;
    wait (rst_n === 1'b1);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Output side: random back-pressure bursts, plus an optional long hold
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (long_hold_cycles - 1) @(negedge clk);
        long_hold_cycles = 0;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers (all start and end on a falling edge)
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] value, input bit start);
    in_data  <= '{data_byte: value, file_start: start};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_offered++;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic send_file(input bit first_flag);
    files_sent++;
    foreach (file_bytes[i]) send_byte(file_bytes[i], (i == 0) ? first_flag : 1'b0);
  endtask

  task automatic send_junk(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Hold input off until every predicted item has come back
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic set_flip(input bit value);
    drain_pixels();
    cfg_valid     <= 1'b1;
    cfg_flip_rows <= value;
    do @(posedge clk); while (!cfg_ready);
    flip_model = value;
    flip_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // 30-byte header with random filler in the unused fields
  task automatic build_header(input logic [7:0] m0, input logic [7:0] m1,
                              input logic [31:0] ofs, input logic [31:0] wf,
                              input logic [31:0] hf, input logic [15:0] bpp);
    file_bytes.delete();
    for (int i = 0; i <= bsr_pkg::POS_BPP_HI; i++)
      file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes[bsr_pkg::POS_MAGIC_LO] = m0;
    file_bytes[bsr_pkg::POS_MAGIC_HI] = m1;
    for (int k = 0; k < 4; k++) begin
      file_bytes[bsr_pkg::POS_OFS_FIRST + k] = ofs[8*k +: 8];
      file_bytes[bsr_pkg::POS_WID_FIRST + k] = wf[8*k +: 8];
      file_bytes[bsr_pkg::POS_HGT_FIRST + k] = hf[8*k +: 8];
    end
    file_bytes[bsr_pkg::POS_BPP_LO] = bpp[7:0];
    file_bytes[bsr_pkg::POS_BPP_HI] = bpp[15:8];
  endtask

  // Well-formed image: header, gap up to the offset, rows with padding
  task automatic build_image(input int w, input int h, input logic [15:0] bpp,
                             input logic [31:0] ofs);
    int px_len;
    build_header(bsr_pkg::MAGIC_B, bsr_pkg::MAGIC_M, ofs, w, h, bpp);
    px_len = (bpp == bsr_pkg::BPP_32) ? 4 : 3;
    while (file_bytes.size() < ofs) file_bytes.push_back(8'($urandom_range(0, 255)));
    for (int r = 0; r < h; r++) begin
      repeat (w * px_len) file_bytes.push_back(8'($urandom_range(0, 255)));
      if (px_len == 3) repeat (w & 3) file_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic truncate_file(input int keep);
    while (file_bytes.size() > keep) void'(file_bytes.pop_back());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // First file after reset carries no start flag
  task automatic test_no_start_flag();
    set_flip(1'b0);
    build_image(2, 2, BPP_24, 54);
    send_file(1'b0);
  endtask

  // Depths, offsets, padding widths and extreme channel values
  task automatic test_header_forms();
    build_image(3, 2, bsr_pkg::BPP_32, 54);
    send_file(1'b1);
    build_image(3, 3, BPP_24, 0);           // offset below header end
    send_file(1'b1);
    set_flip(1'b1);
    build_image(5, 2, 16'd16, 29);          // odd depth handled as 24-bit
    send_file(1'b1);
    build_image(1, 1, 16'h0120, 30);        // high depth byte set, still 24-bit
    send_file(1'b1);
    send_junk(3);                           // ignored after the last pixel
    build_image(2, 2, bsr_pkg::BPP_32, 30);
    for (int i = 30; i < file_bytes.size(); i++)
      file_bytes[i] = (i % 8 < 4) ? 8'h00 : 8'hFF;
    send_file(1'b1);
    set_flip(1'b0);
    build_image(4, 1, 16'hFFFF, 31);
    send_file(1'b1);
  endtask

  task automatic test_bad_magic();
    build_header(bsr_pkg::MAGIC_B, 8'h4E, 54, 2, 2, BPP_24);
    send_file(1'b1);
    send_junk(5);
    build_header(bsr_pkg::MAGIC_M, bsr_pkg::MAGIC_B, 54, 2, 2, BPP_24);
    send_file(1'b1);
    build_header(8'h00, 8'hFF, 54, 2, 2, bsr_pkg::BPP_32);
    send_file(1'b1);
    build_header(8'hFF, 8'h00, 54, 2, 2, bsr_pkg::BPP_32);
    truncate_file(2);
    send_file(1'b1);
  endtask

  task automatic test_bad_size();
    build_header(bsr_pkg::MAGIC_B, bsr_pkg::MAGIC_M, 54, 0, 1, BPP_24);
    send_file(1'b1);
    build_header(bsr_pkg::MAGIC_B, bsr_pkg::MAGIC_M, 54, 1, 0, BPP_24);
    send_file(1'b1);
    build_header(bsr_pkg::MAGIC_B, bsr_pkg::MAGIC_M, 54, DIM_LIMIT + 1, 1,
                 bsr_pkg::BPP_32);
    send_file(1'b1);
    send_junk(10);
    // negative height
    build_header(bsr_pkg::MAGIC_B, bsr_pkg::MAGIC_M, 54, 1, 32'hFFFF_FFFF, BPP_24);
    send_file(1'b1);
    build_header(bsr_pkg::MAGIC_B, bsr_pkg::MAGIC_M, 54, 32'h0001_0000, 5, BPP_24);
    send_file(1'b1);
  endtask

  // Offset beyond any file: everything after the header is skipped
  task automatic test_huge_offset();
    build_header(bsr_pkg::MAGIC_B, bsr_pkg::MAGIC_M, 32'hFFFF_FFFF, 2, 2, BPP_24);
    send_file(1'b1);
    send_junk(60);
    build_image(2, 1, BPP_24, 30);
    send_file(1'b1);
  endtask

  // A new start flag cuts short a file in its pixels and in its header
  task automatic test_restart_mid_image();
    build_image(4, 4, BPP_24, 40);
    truncate_file(60);
    send_file(1'b1);
    build_image(3, 2, bsr_pkg::BPP_32, 54);
    truncate_file(12);
    send_file(1'b1);
    build_image(3, 2, bsr_pkg::BPP_32, 54);
    send_file(1'b1);
  endtask

  // Output held off long enough for the block to back up its input
  task automatic test_long_output_stall();
    drain_pixels();
    long_hold_cycles = 300;
    build_image(8, 8, bsr_pkg::BPP_32, 30);
    send_file(1'b1);
    drain_pixels();
  endtask

  // Largest width and largest height pass the size check; only the first
  // pixels of each are sent, flipped and not
  task automatic test_extreme_dimensions();
    set_flip(1'b0);
    build_image(DIM_LIMIT, 1, bsr_pkg::BPP_32, 54);
    truncate_file(54 + 4 * EDGE_PIXELS);
    send_file(1'b1);
    set_flip(1'b1);
    build_image(1, DIM_LIMIT, BPP_24, 30);
    truncate_file(30 + 4 * EDGE_PIXELS);
    send_file(1'b1);
  endtask

  // Mostly valid small images, with broken files and noise mixed in
  task automatic test_random_files(input int byte_budget);
    int          target;
    int          kind;
    int          count;
    int          w;
    int          h;
    logic [15:0] depth;
    logic [31:0] ofs;
    logic [31:0] wf;
    logic [31:0] hf;
    logic [7:0]  m0;
    logic [7:0]  m1;
    target = bytes_offered + byte_budget;
    count  = 0;
    while (bytes_offered < target) begin
      if (count % 8 == 7) set_flip(1'($urandom_range(0, 1)));
      count++;
      kind = $urandom_range(0, 15);
      w    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
      h    = $urandom_range(1, 5);
      case ($urandom_range(0, 2))
        0: depth = BPP_24;
        1: depth = bsr_pkg::BPP_32;
        default: begin
          depth = 16'($urandom_range(0, 16'hFFFF));
          if (depth == bsr_pkg::BPP_32) depth = BPP_24;
        end
      endcase
      case ($urandom_range(0, 3))
        0: ofs = 54;
        1: ofs = $urandom_range(30, 64);
        default: ofs = $urandom_range(0, 29);
      endcase
      if (kind < 11) begin
        build_image(w, h, depth, ofs);
        send_file(1'b1);
        if ($urandom_range(0, 3) == 0) send_junk($urandom_range(1, 4));
      end else if (kind == 11) begin
        m0 = 8'($urandom_range(0, 255));
        m1 = 8'($urandom_range(0, 255));
        if (m0 == bsr_pkg::MAGIC_B && m1 == bsr_pkg::MAGIC_M) m1 = ~bsr_pkg::MAGIC_M;
        build_header(m0, m1, ofs, w, h, depth);
        truncate_file($urandom_range(2, 30));
        send_file(1'b1);
      end else if (kind == 12) begin
        wf = w;
        hf = h;
        case ($urandom_range(0, 3))
          0: wf = 0;
          1: hf = 0;
          2: wf = $urandom_range(DIM_LIMIT + 1, 32'hFFFF_FFFF);
          default: hf = $urandom | 32'h8000_0000;
        endcase
        build_header(bsr_pkg::MAGIC_B, bsr_pkg::MAGIC_M, ofs, wf, hf, depth);
        send_file(1'b1);
        send_junk($urandom_range(0, 8));
      end else if (kind == 13) begin
        build_image(w, h, depth, ofs);
        truncate_file($urandom_range(1, file_bytes.size() - 1));
        send_file(1'b1);
      end else begin
        repeat ($urandom_range(5, 20))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    cfg_valid        = 1'b0;
    cfg_flip_rows    = 1'b0;
    mismatches       = 0;
    bytes_offered    = 0;
    files_sent       = 0;
    pixels_checked   = 0;
    errors_checked   = 0;
    flip_writes      = 0;
    long_hold_cycles = 0;
    src_idle_en      = 1'b1;
    sink_idle_en     = 1'b1;
    flip_model       = 1'b0;
    clear_parser();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_no_start_flag();
    test_header_forms();
    test_bad_magic();
    test_bad_size();
    test_huge_offset();
    test_restart_mid_image();
    test_long_output_stall();
    test_extreme_dimensions();
    test_random_files(200);
    // closing stretch at full rate on both sides
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_files(150);

    drain_pixels();
    repeat (8) @(negedge clk);
    if (pixels_due.size() != 0) begin
      mismatches += pixels_due.size();
      $display("%0d predicted items never arrived", pixels_due.size());
    end

    $display("Sent %0d bytes in %0d files; checked %0d pixels and %0d error items.",
             bytes_offered, files_sent, pixels_checked, errors_checked);
    $display("Row flip written %0d times; %0d mismatches.", flip_writes, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- bmp_stream_to_rgba.f -----
hdl/bsr_pkg.sv
hdl/bsr_parse.sv
hdl/bsr_outbuf.sv
hdl/bmp_stream_to_rgba.sv
hdl/bsr_checker.sv
tb/tb_top.sv
